FILE: rtl/core/dvp_pkg.sv
// Shared types and constants of the decimal vector parser.
`default_nettype none

package dvp_pkg;

   // Character codes the parser recognizes
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Separator register reset value (comma)
   localparam logic [7:0] SEP_RESET = 8'd44;

   // Register index of the separator (word index on the csr port)
   localparam logic REG_SEPARATOR = 1'b0;

   // Defaults for the top level parameters
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int FRAC_DIGITS_DEFAULT = 6;

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // One classified character as it travels from front to back
   typedef struct packed {
      logic       start;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_minus;
      logic       is_dot;
      logic       is_sep;
   } dvp_char_type;

   // One finished parse result
   typedef struct packed {
      logic [7:0]  consumed;
      logic        overflow;
      logic        ok;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } dvp_result_type;

endpackage

`default_nettype wire

FILE: rtl/core/dvp_front.sv
// Front end: takes characters from the request stream and classifies them.
`default_nettype none

module dvp_front (
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] char_in
   input  wire logic                   req_tuser,   // [0] start_vector
   input  wire logic [7:0]             separator,
   input  wire logic                   queue_full,
   output logic                        push,
   output dvp_pkg::dvp_char_type       push_data
);
   import dvp_pkg::*;

   logic is_digit;

   // Accept whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Classify the character
   assign is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);

   always_comb begin
      push_data.start    = req_tuser;
      push_data.is_digit = is_digit;
      push_data.digit    = is_digit ? 4'(req_tdata - CHAR_ZERO) : 4'd0;
      push_data.is_minus = (req_tdata == CHAR_MINUS);
      push_data.is_dot   = (req_tdata == CHAR_DOT);
      push_data.is_sep   = (req_tdata == separator);
   end

endmodule

`default_nettype wire

FILE: rtl/core/dvp_queue.sv
// Two-entry queue of classified characters between front and back.
`default_nettype none

module dvp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dvp_pkg::dvp_char_type  push_data,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        valid,
   output dvp_pkg::dvp_char_type       head
);
   import dvp_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dvp_char_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   assert property (@(posedge clock) disable iff (reset)
      !valid |-> !pop)
      else $error("queue read while empty");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count out of range");

endmodule

`default_nettype wire

FILE: rtl/core/dvp_back.sv
// Back end: number parsing state machine and the result output register.
`default_nettype none

module dvp_back #(
   parameter int FRAC_BITS   = dvp_pkg::FRAC_BITS_DEFAULT,
   parameter int FRAC_DIGITS = dvp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire dvp_pkg::dvp_char_type  q_head,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output dvp_pkg::dvp_result_type     rsp_result
);
   import dvp_pkg::*;

   // Integer part geometry
   localparam int IW        = 32 - FRAC_BITS;
   localparam int NW        = IW + 4;
   localparam int INT_CAP   = (1 << (31 - FRAC_BITS)) - 1;
   localparam int INT_LIMIT = (32767 < INT_CAP) ? 32767 : INT_CAP;
   localparam logic [NW-1:0] LIMIT_N   = NW'(INT_LIMIT);
   localparam logic [31:0]   LIMIT_ACC = 32'(INT_LIMIT) << FRAC_BITS;
   localparam logic [2:0]    FD_MAX    = 3'(FRAC_DIGITS);
   localparam logic [35:0]   MAG_MAX   = 36'h07FFFFFFF;

   // Rounded weight of each fraction digit position
   localparam longint unsigned ONE2 = 64'd1 << (FRAC_BITS + 1);
   localparam longint unsigned W0 = (ONE2 / 64'd10 + 64'd1) >> 1;
   localparam longint unsigned W1 = (ONE2 / 64'd100 + 64'd1) >> 1;
   localparam longint unsigned W2 = (ONE2 / 64'd1000 + 64'd1) >> 1;
   localparam longint unsigned W3 = (ONE2 / 64'd10000 + 64'd1) >> 1;
   localparam longint unsigned W4 = (ONE2 / 64'd100000 + 64'd1) >> 1;
   localparam longint unsigned W5 = (ONE2 / 64'd1000000 + 64'd1) >> 1;
   localparam longint unsigned W6 = (ONE2 / 64'd10000000 + 64'd1) >> 1;
   localparam logic [31:0] WEIGHT [8] = '{32'(W0), 32'(W1), 32'(W2), 32'(W3),
                                         32'(W4), 32'(W5), 32'(W6), 32'd0};

   typedef enum logic [1:0] {PH_SIGN, PH_INT, PH_FRAC} phase_type;

   // Parse state
   logic           active_ff,   active_in;
   logic [1:0]     comp_ff,     comp_in;
   phase_type      phase_ff,    phase_in;
   logic [31:0]    acc_ff,      acc_in;
   logic [2:0]     frac_cnt_ff, frac_cnt_in;
   logic           neg_ff,      neg_in;
   logic [31:0]    saved_x_ff,  saved_x_in;
   logic [31:0]    saved_y_ff,  saved_y_in;
   logic [7:0]     count_ff,    count_in;
   logic           ovf_ff,      ovf_in;
   logic           rsp_valid_ff, rsp_valid_in;
   dvp_result_type rsp_ff,      rsp_in;

   // State as seen by this character (a start clears it first)
   logic           e_active;
   logic [1:0]     e_comp;
   phase_type      e_phase;
   logic [31:0]    e_acc;
   logic [2:0]     e_frac_cnt;
   logic           e_neg;
   logic [31:0]    e_saved_x;
   logic [31:0]    e_saved_y;
   logic [7:0]     e_count;
   logic           e_ovf;

   logic [NW-1:0]  int_n;
   logic           int_sat;
   logic [31:0]    int_acc;
   logic [35:0]    frac_sum;
   logic [31:0]    frac_acc;
   logic [31:0]    cur_val;
   logic [7:0]     count_inc;
   logic           emit;
   logic           emit_ok;
   logic           emit_cur;
   logic           do_step;

   assign q_pop      = q_valid && (!rsp_valid_ff || rsp_tready);
   assign do_step    = q_pop && e_active;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   // Effective state
   always_comb begin
      if (q_head.start) begin
         e_active   = 1'b1;
         e_comp     = 2'd0;
         e_phase    = PH_SIGN;
         e_acc      = '0;
         e_frac_cnt = '0;
         e_neg      = 1'b0;
         e_saved_x  = '0;
         e_saved_y  = '0;
         e_count    = '0;
         e_ovf      = 1'b0;
      end else begin
         e_active   = active_ff;
         e_comp     = comp_ff;
         e_phase    = phase_ff;
         e_acc      = acc_ff;
         e_frac_cnt = frac_cnt_ff;
         e_neg      = neg_ff;
         e_saved_x  = saved_x_ff;
         e_saved_y  = saved_y_ff;
         e_count    = count_ff;
         e_ovf      = ovf_ff;
      end
   end

   // Integer digit: times ten plus digit, clamped
   always_comb begin
      int_n   = {4'b0, e_acc[31:FRAC_BITS]} * NW'(10) + NW'(q_head.digit);
      int_sat = (int_n > LIMIT_N);
      int_acc = int_sat ? LIMIT_ACC : (32'(int_n) << FRAC_BITS);
   end

   // Fraction digit: add digit times rounded weight, clamped
   always_comb begin
      frac_sum = {4'b0, e_acc} + 36'(WEIGHT[e_frac_cnt]) * 36'(q_head.digit);
      frac_acc = (frac_sum > MAG_MAX) ? MAG_MAX[31:0] : frac_sum[31:0];
   end

   assign cur_val   = e_neg ? (32'd0 - e_acc) : e_acc;
   assign count_inc = (e_count == 8'd255) ? e_count : e_count + 8'd1;

   // Character handling
   always_comb begin
      active_in   = e_active;
      comp_in     = e_comp;
      phase_in    = e_phase;
      acc_in      = e_acc;
      frac_cnt_in = e_frac_cnt;
      neg_in      = e_neg;
      saved_x_in  = e_saved_x;
      saved_y_in  = e_saved_y;
      count_in    = e_count;
      ovf_in      = e_ovf;
      emit        = 1'b0;
      emit_ok     = 1'b0;
      emit_cur    = 1'b1;
      case (e_phase)
         PH_SIGN: begin
            if (q_head.is_minus) begin
               neg_in   = 1'b1;
               phase_in = PH_INT;
               count_in = count_inc;
            end else if (q_head.is_digit) begin
               acc_in   = int_acc;
               ovf_in   = e_ovf | int_sat;
               phase_in = PH_INT;
               count_in = count_inc;
            end else if (q_head.is_dot) begin
               phase_in = PH_FRAC;
               count_in = count_inc;
            end else begin
               emit     = 1'b1;
               emit_cur = 1'b0;
            end
         end
         PH_INT: begin
            if (q_head.is_digit) begin
               acc_in   = int_acc;
               ovf_in   = e_ovf | int_sat;
               count_in = count_inc;
            end else if (q_head.is_dot) begin
               phase_in = PH_FRAC;
               count_in = count_inc;
            end else begin
               emit = 1'b1;
            end
         end
         PH_FRAC: begin
            if (q_head.is_digit) begin
               if (e_frac_cnt < FD_MAX) begin
                  acc_in      = frac_acc;
                  frac_cnt_in = e_frac_cnt + 3'd1;
               end
               count_in = count_inc;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            emit     = 1'b1;
            emit_cur = 1'b0;
         end
      endcase

      // End of a number: third one finishes, else a separator moves on
      if (emit && e_phase != PH_SIGN) begin
         if (e_comp == 2'd2) begin
            emit_ok = 1'b1;
         end else if (q_head.is_sep) begin
            emit = 1'b0;
            if (e_comp == 2'd0) begin
               saved_x_in = cur_val;
            end else begin
               saved_y_in = cur_val;
            end
            comp_in     = e_comp + 2'd1;
            phase_in    = PH_SIGN;
            acc_in      = '0;
            frac_cnt_in = '0;
            neg_in      = 1'b0;
            count_in    = count_inc;
         end
      end
      if (emit) begin
         active_in = 1'b0;
      end
   end

   // Result assembly
   always_comb begin
      rsp_in.x        = (e_comp == 2'd0) ? (emit_cur ? cur_val : 32'd0) : e_saved_x;
      rsp_in.y        = (e_comp == 2'd0) ? 32'd0 :
                        (e_comp == 2'd1) ? (emit_cur ? cur_val : 32'd0) : e_saved_y;
      rsp_in.z        = (e_comp == 2'd2 && emit_cur) ? cur_val : 32'd0;
      rsp_in.ok       = emit_ok;
      rsp_in.overflow = e_ovf;
      rsp_in.consumed = e_count;
      if (do_step && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         comp_ff      <= 2'd0;
         phase_ff     <= PH_SIGN;
         acc_ff       <= '0;
         frac_cnt_ff  <= '0;
         neg_ff       <= 1'b0;
         saved_x_ff   <= '0;
         saved_y_ff   <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_step) begin
            active_ff   <= active_in;
            comp_ff     <= comp_in;
            phase_ff    <= phase_in;
            acc_ff      <= acc_in;
            frac_cnt_ff <= frac_cnt_in;
            neg_ff      <= neg_in;
            saved_x_ff  <= saved_x_in;
            saved_y_ff  <= saved_y_in;
            count_ff    <= count_in;
            ovf_ff      <= ovf_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (do_step && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // A parse only ends by loading a result
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $fell(active_ff) |-> rsp_valid_ff)
      else $error("parse ended without a result");

   // A successful parse has read at least three numbers and two separators
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ok |-> rsp_ff.consumed >= 8'd5)
      else $error("ok result with too few characters");

   // A third component only appears on a successful parse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.z != 32'd0) |-> rsp_ff.ok)
      else $error("third component without success");

   // Component index stays within the three numbers
   assert property (@(posedge clock) disable iff (reset)
      comp_ff != 2'd3)
      else $error("component index out of range");

endmodule

`default_nettype wire

FILE: rtl/core/decimal_vector_parser_core.sv
// Top level of the decimal vector parser: csr register, front, queue and back.
//
//   channel  | direction | handshake          | contents
//   req_     | in        | tvalid/tready      | tdata: char_in; tuser: start_vector
//   rsp_     | out       | tvalid/tready      | tdata: x, y, z, parse_ok, overflow, count
//   csr_     | in/out    | psel/penable/pready| separator_char at byte address 0
//
// One character per cycle is sustained while rsp_ is not stalled; each character is
// classified, queued and taken by the back step (times ten plus a table weight add).
// A result appears on rsp_ in the cycle after its stopping character leaves the queue.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stalled rsp_ holds the back; the two-entry queue then absorbs characters.
`default_nettype none

module decimal_vector_parser_core #(
   parameter int FRAC_BITS   = dvp_pkg::FRAC_BITS_DEFAULT,
   parameter int FRAC_DIGITS = dvp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [dvp_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] char_in
   input  wire logic                            req_tuser,  // [0] start_vector
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [31:0] x_value, [63:32] y_value, [95:64] z_value, [96] parse_ok,
   // [97] overflow_flag, [105:98] chars_consumed, [111:106] zero
   output logic [dvp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [dvp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [dvp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dvp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import dvp_pkg::*;

   logic [7:0]     sep_ff, sep_in;
   logic           csr_write;
   logic           reg_index;
   logic           q_full;
   logic           q_push;
   dvp_char_type   q_push_data;
   logic           q_pop;
   logic           q_valid;
   dvp_char_type   q_head;
   dvp_result_type result;

   // Configuration register
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sep_in     = (csr_write && reg_index == REG_SEPARATOR) ? csr_pwdata[7:0] : sep_ff;
   assign csr_prdata = (reg_index == REG_SEPARATOR) ? {24'd0, sep_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
      end else begin
         sep_ff <= sep_in;
      end
   end

   dvp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .separator  (sep_ff),
      .queue_full (q_full),
      .push       (q_push),
      .push_data  (q_push_data)
   );

   dvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   dvp_back #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   // Pack the result, first field lowest
   assign rsp_tdata = {6'd0, result.consumed, result.overflow, result.ok,
                       result.z, result.y, result.x};

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the decimal vector parser core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dvp_pkg::*;

   localparam int FRAC_BITS   = FRAC_BITS_DEFAULT;
   localparam int FRAC_DIGITS = FRAC_DIGITS_DEFAULT;
   localparam int INT_CAP     = (1 << (31 - FRAC_BITS)) - 1;
   localparam int INT_LIMIT   = (INT_CAP < 32767) ? INT_CAP : 32767;
   localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;
   localparam logic [CSR_ADDR_W-1:0] SEP_ADDR = {REG_SEPARATOR, 2'b00};
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;

   typedef enum logic [1:0] {PH_SIGN, PH_INT, PH_FRAC} digit_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] char_in
   logic req_tuser = 1'b0;                  // [0] start_vector
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [31:0] x_value, [63:32] y_value, [95:64] z_value, [96] parse_ok,
   // [97] overflow_flag, [105:98] chars_consumed, [111:106] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   decimal_vector_parser_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // Parser mirror state
   logic [7:0]      sep_mirror = SEP_RESET;
   bit              vec_active;
   int unsigned     comp_idx;
   digit_phase_type num_phase;
   logic [31:0]     magnitude;
   int unsigned     frac_count;
   bit              neg_sign;
   logic [31:0]     saved_x, saved_y;
   int unsigned     char_count;
   bit              int_sat;

   dvp_result_type expected_vectors[$];
   logic [7:0] text_q[$];
   bit         start_q[$];

   int mismatches = 0;
   int results_checked = 0;
   int chars_sent = 0;
   int sep_settings = 0;
   int cycle_count = 0;
   int src_idle_rate = 0;
   int sink_stall_rate = 0;
   int stall_left = 0;

   dvp_result_type want, got;

   // ---------------- predictor ----------------
   function automatic void clear_number();
      num_phase  = PH_SIGN;
      magnitude  = '0;
      frac_count = 0;
      neg_sign   = 1'b0;
   endfunction

   function automatic void clear_vector();
      vec_active = 1'b0;
      comp_idx   = 0;
      clear_number();
      saved_x    = '0;
      saved_y    = '0;
      char_count = 0;
      int_sat    = 1'b0;
   endfunction

   function automatic void count_char();
      if (char_count < 255) char_count++;
   endfunction

   function automatic logic [31:0] signed_component();
      return neg_sign ? (32'd0 - magnitude) : magnitude;
   endfunction

   // Rounded weight of the k-th digit after the dot
   function automatic logic [63:0] frac_weight(int unsigned k);
      logic [63:0] p;
      p = 64'd10;
      repeat (k) p = p * 64'd10;
      return ((64'd1 << (FRAC_BITS + 1)) / p + 64'd1) >> 1;
   endfunction

   function automatic void add_int(logic [3:0] d);
      logic [63:0] n;
      n = 64'(magnitude >> FRAC_BITS) * 64'd10 + 64'(d);
      if (n > 64'(INT_LIMIT)) begin
         n = 64'(INT_LIMIT);
         int_sat = 1'b1;
      end
      magnitude = 32'(n << FRAC_BITS);
   endfunction

   function automatic void add_frac(logic [3:0] d);
      logic [63:0] sum;
      // digits past the table width are consumed but add nothing
      if (frac_count < FRAC_DIGITS && frac_count < 7) begin
         sum = {32'd0, magnitude} + frac_weight(frac_count) * 64'(d);
         magnitude = (sum > 64'(MAG_MAX)) ? MAG_MAX : sum[31:0];
         frac_count++;
      end
   endfunction

   function automatic dvp_result_type finish_vector(bit ok, bit with_current);
      dvp_result_type r;
      r = '0;
      if (comp_idx > 0) r.x = saved_x;
      if (comp_idx > 1) r.y = saved_y;
      if (with_current) begin
         case (comp_idx)
            0: r.x = signed_component();
            1: r.y = signed_component();
            default: r.z = signed_component();
         endcase
      end
      r.ok       = ok;
      r.overflow = int_sat;
      r.consumed = 8'(char_count);
      vec_active = 1'b0;
      return r;
   endfunction

   // A non-number character closes the current component
   function automatic bit end_number(logic [7:0] c, output dvp_result_type r);
      r = '0;
      if (comp_idx >= 2) begin
         r = finish_vector(1'b1, 1'b1);
         return 1'b1;
      end
      if (c != sep_mirror) begin
         r = finish_vector(1'b0, 1'b1);
         return 1'b1;
      end
      if (comp_idx == 0) saved_x = signed_component();
      else saved_y = signed_component();
      comp_idx++;
      clear_number();
      count_char();
      return 1'b0;
   endfunction

   // Advance the mirror by one character; returns 1 when a result is due
   function automatic bit parse_char(logic [7:0] c, bit start, output dvp_result_type r);
      bit is_digit;
      logic [3:0] d;
      is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      d = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
      r = '0;
      if (start) begin
         clear_vector();
         vec_active = 1'b1;
      end
      if (!vec_active) return 1'b0;
      case (num_phase)
         PH_SIGN: begin
            if (c == CHAR_MINUS) begin
               neg_sign  = 1'b1;
               num_phase = PH_INT;
            end else if (is_digit) begin
               add_int(d);
               num_phase = PH_INT;
            end else if (c == CHAR_DOT) begin
               num_phase = PH_FRAC;
            end else begin
               r = finish_vector(1'b0, 1'b0);
               return 1'b1;
            end
            count_char();
            return 1'b0;
         end
         PH_INT: begin
            if (is_digit) add_int(d);
            else if (c == CHAR_DOT) num_phase = PH_FRAC;
            else return end_number(c, r);
            count_char();
            return 1'b0;
         end
         default: begin
            if (is_digit) begin
               add_frac(d);
               count_char();
               return 1'b0;
            end
            return end_number(c, r);
         end
      endcase
   endfunction

   // ---------------- result side ----------------
   // Receiver stalls in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (sink_stall_rate != 0 && $urandom_range(1, sink_stall_rate) == 1) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vectors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result with nothing expected: %h", $realtime, rsp_tdata);
         end else begin
            want = expected_vectors.pop_front();
            got  = dvp_result_type'(rsp_tdata[105:0]);
            results_checked++;
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.ok !== want.ok || got.overflow !== want.overflow ||
                got.consumed !== want.consumed || rsp_tdata[111:106] !== 6'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"[%0t] mismatch exp x=%h y=%h z=%h ok=%b ovf=%b n=%0d",
                            " | got x=%h y=%h z=%h ok=%b ovf=%b n=%0d pad=%b"},
                     $realtime, want.x, want.y, want.z, want.ok, want.overflow,
                     want.consumed, got.x, got.y, got.z, got.ok, got.overflow,
                     got.consumed, rsp_tdata[111:106]);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_vectors.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- input side ----------------
   // One character transfer, with an optional idle burst ahead of it
   task automatic send_item(logic [7:0] c, bit s);
      dvp_result_type r;
      if (src_idle_rate != 0 && $urandom_range(1, src_idle_rate) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= s;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      if (parse_char(c, s, r)) expected_vectors.push_back(r);
   endtask

   task automatic push_char(logic [7:0] c, bit s);
      text_q.push_back(c);
      start_q.push_back(s);
   endtask

   // Queue a string, the first character starting a new vector
   task automatic push_text(string str);
      for (int i = 0; i < str.len(); i++) push_char(str[i], i == 0);
   endtask

   task automatic send_queued();
      foreach (text_q[i]) send_item(text_q[i], start_q[i]);
      text_q.delete();
      start_q.delete();
   endtask

   function automatic logic [7:0] rand_digit(bit nines);
      return nines ? CHAR_NINE : 8'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   // Optional sign, integer digits, optional dot and fraction digits
   task automatic push_number();
      int n_int;
      bit nines;
      nines = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) push_char(CHAR_MINUS, 1'b0);
      n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
      repeat (n_int) push_char(rand_digit(nines), 1'b0);
      if ($urandom_range(0, 1) == 1) begin
         push_char(CHAR_DOT, 1'b0);
         repeat ($urandom_range(0, 8)) push_char(rand_digit(nines), 1'b0);
      end
   endtask

   // Mostly well-formed vectors; some broken ones and some noise
   task automatic push_random_vector();
      int kind, first;
      logic [7:0] wrong;
      kind  = $urandom_range(0, 9);
      first = text_q.size();
      if (kind == 9) begin
         repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)),
                                                  $urandom_range(0, 5) == 0);
         return;
      end
      wrong = sep_mirror ^ (8'd1 << $urandom_range(0, 7));
      push_number();
      push_char((kind == 8 && $urandom_range(0, 1) == 1) ? wrong : sep_mirror, 1'b0);
      push_number();
      // truncated vector: the next start abandons it
      if (kind == 7) begin
         if (text_q.size() > first) start_q[first] = 1'b1;
         return;
      end
      push_char((kind == 8 && $urandom_range(0, 1) == 1) ? wrong : sep_mirror, 1'b0);
      push_number();
      push_char(($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(0, 255)), 1'b0);
      if (text_q.size() > first) start_q[first] = 1'b1;
   endtask

   task automatic run_random(int n_chars);
      int stop_at;
      stop_at = chars_sent + n_chars;
      while (chars_sent < stop_at) begin
         src_idle_rate   = ($urandom_range(0, 3) == 0) ? 0 : 6;
         sink_stall_rate = ($urandom_range(0, 3) == 0) ? 0 : 5;
         push_random_vector();
         send_queued();
      end
   endtask

   // Close any open parse and let the pipeline run dry
   task automatic settle_parser();
      push_char("!", 1'b1);
      send_queued();
      req_tvalid <= 1'b0;
      while (expected_vectors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------- register port ----------------
   task automatic write_separator(logic [7:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEP_ADDR;
      csr_pwdata  <= {24'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      sep_mirror = v;
      sep_settings++;
   endtask

   task automatic check_separator_readback();
      logic [CSR_DATA_W-1:0] rd;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SEP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== {24'd0, sep_mirror}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] separator readback exp %h got %h", $realtime, sep_mirror, rd);
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_register();
      check_separator_readback();
   endtask

   task automatic test_directed_cases();
      src_idle_rate   = 0;
      sink_stall_rate = 0;
      push_text("1.5,-2.25,3");      push_char(8'h00, 1'b0);
      // lone sign and lone dot read as zero
      push_text("-,.,-.");           push_char(8'h00, 1'b0);
      // integer saturation
      push_text("99999.5,-123456,7"); push_char(8'h00, 1'b0);
      // fraction carry past the top, digits past the table
      push_text("32767.999999,-32767.9999999,0.0000001"); push_char(" ", 1'b0);
      // missing separator keeps x, empty numbers fail
      push_text("1;2,3");            push_char(8'h00, 1'b0);
      push_text(",");
      push_text("1,,3");             push_char(8'h00, 1'b0);
      // restart abandons an open parse
      push_text("1,2");
      push_text("4,5,6");            push_char(8'hFF, 1'b0);
      // idle characters are ignored
      push_char("a", 1'b0);
      push_char("7", 1'b0);
      push_text("0,0,0");            push_char("+", 1'b0);
      send_queued();
      settle_parser();
   endtask

   task automatic test_separator_settings();
      logic [7:0] seps[8];
      seps = '{8'h00, 8'hFF, ";", "-", ".", " ", 8'h00, SEP_RESET};
      seps[6] = 8'($urandom_range(0, 255));
      foreach (seps[i]) begin
         settle_parser();
         write_separator(seps[i]);
         check_separator_readback();
         run_random(60);
      end
      settle_parser();
   endtask

   // A vector longer than 255 characters saturates the count
   task automatic test_saturating_count();
      src_idle_rate   = 6;
      sink_stall_rate = 5;
      push_text("1.");
      repeat (300) push_char(rand_digit(1'b0), 1'b0);
      push_char(sep_mirror, 1'b0);
      push_char("2", 1'b0);
      push_char(sep_mirror, 1'b0);
      push_char("3", 1'b0);
      push_char(8'h00, 1'b0);
      send_queued();
   endtask

   task automatic test_random_traffic();
      run_random(200);
   endtask

   // Back-to-back transfers with no idling on either side
   task automatic test_full_rate();
      int stop_at;
      stop_at = chars_sent + 120;
      while (chars_sent < stop_at) begin
         src_idle_rate   = 0;
         sink_stall_rate = 0;
         push_random_vector();
         send_queued();
      end
      push_char(8'h00, 1'b1);
      send_queued();
   endtask

   initial begin
      clear_vector();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_register();
      test_directed_cases();
      test_separator_settings();
      test_saturating_count();
      test_random_traffic();
      test_full_rate();

      req_tvalid <= 1'b0;
      while (expected_vectors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters under %0d separator settings; %0d parse results checked.",
               chars_sent, sep_settings, results_checked);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
